### rtl/bti_pkg.sv
// package for the breakpoint table interpolator
// shared word types, command and status codes, sequencer states; no dependencies
package bti_pkg;

  localparam int TableDepth = 256;
  localparam int TimeBits   = 32;
  localparam int ValueBits  = 32;
  localparam int CountBits  = 9;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DUP   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] time_in;
    logic signed [31:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic signed [31:0] value_out;
    logic [8:0]  point_count;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PAIR_RD0,
    S_PAIR_RD1,
    S_PAIR_WAIT,
    S_MUL,
    S_DIV,
    S_DONE,
    S_OUT
  } state_t;

endpackage

### rtl/bti_ram.sv
// point table memory: one write port, one registered read port
// depends on nothing but its parameters
module bti_ram #(
  parameter int Depth = 256,
  parameter int Width = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // synchronous write and read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bti_div.sv
// restoring divider, one quotient bit per cycle
// depends on its parameters only
module bti_div #(
  parameter int NumBits = 64,
  parameter int DenBits = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NumBits-1:0] num,
  input  logic [DenBits-1:0] den,
  output logic               busy,
  output logic [NumBits-1:0] quot
);

  localparam int CntBits = $clog2(NumBits + 1);

  logic [DenBits-1:0] rem;
  logic [NumBits-1:0] sh;
  logic [CntBits-1:0] cnt;
  logic [DenBits:0]   trial;
  logic [DenBits:0]   diff;

  assign trial = {rem, sh[NumBits-1]};
  assign diff  = trial - {1'b0, den};

  // shift in one numerator bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntBits'(NumBits);
      rem  <= '0;
      sh   <= num;
    end else if (busy) begin
      sh <= {sh[NumBits-2:0], 1'b0};
      if (!diff[DenBits]) begin
        rem  <= diff[DenBits-1:0];
        quot <= {quot[NumBits-2:0], 1'b1};
      end else begin
        rem  <= trial[DenBits-1:0];
        quot <= {quot[NumBits-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntBits'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  a_cnt : assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with zero count");
  a_start : assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_done : assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == CntBits'(1) && !start) |=> !busy)
    else $error("divider overran");

endmodule

### rtl/breakpoint_table_interpolator.sv
// Breakpoint table interpolator top level.
// Channels: in (in_valid, in_stall, in_word) carries one command word per item:
// clear, insert a (time, value) point in time order, or query the value at a time.
// out (out_valid, out_stall, out_word) returns one result word per item with
// status, queried value, point count and running minimum and maximum.
// Points live in a single one-port-read synchronous memory of TABLE_DEPTH rows.
// Clear, no-op, empty query and first insert go straight to the result word;
// an insert runs a binary search, then moves entries up when needed; a query runs
// a binary search and the bit-serial divider, skipping the divider when the time
// falls outside the table or on a point, or the table holds a single point.
// One item is in work at a time and the next is taken in the cycle after the
// result word leaves.
// in_stall is high whenever an item is in work or a result waits in the
// output register. While out_stall is high the result word holds steady.
// Reset empties the table (count, minimum and maximum to zero) at once;
// memory contents are left as they are; rows never written do not affect a result.
module breakpoint_table_interpolator #(
  parameter int TABLE_DEPTH = bti_pkg::TableDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bti_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output bti_pkg::out_word_t out_word
);

  import bti_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int TB = TimeBits;
  localparam int VB = ValueBits;
  localparam int NB = TB + VB + 1;

  state_t state, state_next;

  logic [CountBits-1:0] count;
  logic signed [VB-1:0] vmin, vmax;
  in_word_t             cur;

  // search bounds (indices into table, with room for count)
  logic [CountBits-1:0] lo, hi, pos;
  logic [AW-1:0]        raddr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [TB+VB-1:0]     wdata, rdata;
  logic [TB-1:0]        rt;
  logic signed [VB-1:0] rv;
  logic [TB-1:0]        tl;
  logic signed [VB-1:0] vl;
  logic [TB-1:0]        dt, span;
  logic [VB:0]          mag;
  logic                 neg;
  logic [NB-1:0]        prod;
  logic                 div_start, div_busy;
  logic [NB-1:0]        quot;
  logic [CountBits-1:0] mid;
  logic [1:0]           status;
  logic signed [VB-1:0] result;
  logic                 shifting;
  logic [1:0]           sub;
  logic                 first;
  logic                 div_fin;

  assign rt = rdata[TB+VB-1:VB];
  assign rv = rdata[VB-1:0];
  assign mid = lo + ((hi - lo) >> 1);

  bti_ram #(.Depth(TABLE_DEPTH), .Width(TB + VB)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  bti_div #(.NumBits(NB), .DenBits(TB)) u_div (
    .clk, .rst, .start(div_start), .num(prod), .den(span),
    .busy(div_busy), .quot
  );

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // interpolation finished: end case taken or divider drained
  assign div_fin = (state == S_DIV) && (sub == 2'd3) && (first || !div_busy);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = AW'(pos);
    wdata      = {cur.time_in, cur.value_in};
    raddr      = AW'(mid);
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DONE;
          if (in_word.cmd == CMD_INSERT && count != '0) begin
            state_next = S_SRCH_RD;
          end
          if (in_word.cmd == CMD_QUERY && count != '0) begin
            state_next = S_PAIR_RD0;
          end
          // first point goes straight into row zero
          if (in_word.cmd == CMD_INSERT && count == '0) begin
            we    = 1'b1;
            waddr = '0;
            wdata = {in_word.time_in, in_word.value_in};
          end
        end
      end
      // insert: binary search for first entry with time >= t, over [lo,hi)
      S_SRCH_RD: begin
        state_next = (lo == hi) ? S_SHIFT_RD : S_SRCH_CMP;
        raddr = AW'(mid);
      end
      S_SRCH_CMP: begin
        state_next = S_SRCH_RD;
      end
      // check duplicate at pos, shift entries up from the top, then place the point
      S_SHIFT_RD: begin
        raddr = shifting ? AW'(hi - 1'b1) : AW'(pos);
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_next = S_SHIFT_RD;
        if (!shifting) begin
          if (pos < count && rt == cur.time_in) begin
            state_next = S_DONE;
          end else if (count >= CountBits'(TABLE_DEPTH)) begin
            state_next = S_DONE;
          end else if (hi == pos) begin
            we = 1'b1;
            state_next = S_DONE;
          end
        end else if (hi == pos) begin
          we = 1'b1;
          state_next = S_DONE;
        end else begin
          we    = 1'b1;
          waddr = AW'(hi);
          wdata = rdata;
        end
      end
      // query: search for largest lo with time <= t, hi starting at the last entry
      S_PAIR_RD0: begin
        raddr = AW'(mid);
        state_next = (hi - lo > 1) ? S_PAIR_RD0 : S_PAIR_RD1;
        if (hi - lo > 1) begin
          state_next = S_PAIR_WAIT;
        end
      end
      S_PAIR_WAIT: begin
        state_next = S_PAIR_RD0;
      end
      S_PAIR_RD1: begin
        raddr = AW'(lo);
        state_next = S_MUL;
      end
      S_MUL: begin
        raddr = AW'(lo + 1'b1);
        state_next = S_DIV;
      end
      S_DIV: begin
        state_next = div_fin ? S_DONE : S_DIV;
      end
      S_DONE: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_DIV && sub == 2'd2) begin
      div_start = 1'b1;
    end
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      vmin     <= '0;
      vmax     <= '0;
      shifting <= 1'b0;
      sub      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur      <= in_word;
            status   <= (in_word.cmd == CMD_QUERY && count == '0) ? ST_EMPTY : ST_OK;
            result   <= '0;
            lo       <= '0;
            hi       <= (in_word.cmd == CMD_QUERY) ? count - 1'b1 : count;
            pos      <= '0;
            shifting <= 1'b0;
            sub      <= '0;
            first    <= 1'b1;
            if (in_word.cmd == CMD_CLEAR) begin
              count <= '0;
              vmin  <= '0;
              vmax  <= '0;
            end else if (in_word.cmd == CMD_INSERT && count == '0) begin
              // first insert into an empty table
              count <= CountBits'(1);
              vmin  <= in_word.value_in;
              vmax  <= in_word.value_in;
            end
          end
        end
        S_SRCH_RD: begin
          if (lo == hi) begin
            pos <= lo;
          end
        end
        S_SRCH_CMP: begin
          if (rt < cur.time_in) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
        end
        S_SHIFT_RD: begin
          if (!shifting) begin
            hi <= count;
          end
        end
        S_SHIFT_WR: begin
          if (!shifting) begin
            if (pos < count && rt == cur.time_in) begin
              status <= ST_DUP;
            end else if (count >= CountBits'(TABLE_DEPTH)) begin
              status <= ST_FULL;
            end else if (hi == pos) begin
              count <= count + 1'b1;
              if (cur.value_in < vmin) vmin <= cur.value_in;
              if (cur.value_in > vmax) vmax <= cur.value_in;
            end else begin
              shifting <= 1'b1;
            end
          end else if (hi == pos) begin
            count <= count + 1'b1;
            if (cur.value_in < vmin) vmin <= cur.value_in;
            if (cur.value_in > vmax) vmax <= cur.value_in;
          end else begin
            hi <= hi - 1'b1;
          end
        end
        S_PAIR_WAIT: begin
          if (rt <= cur.time_in) begin
            lo <= mid;
          end else begin
            hi <= mid;
          end
        end
        S_MUL: begin
          // rdata holds entry lo
          tl <= rt;
          vl <= rv;
        end
        S_DIV: begin
          unique case (sub)
            2'd0: begin
              // rdata holds entry lo+1; handle ends, a single point and exact hits
              dt   <= cur.time_in - tl;
              span <= rt - tl;
              neg  <= rv < vl;
              mag  <= (rv < vl) ? ((VB+1)'(vl) - (VB+1)'(rv))
                                : ((VB+1)'(rv) - (VB+1)'(vl));
              if (cur.time_in <= tl || count == CountBits'(1)) begin
                result <= vl;
                sub    <= 2'd3;
              end else if (cur.time_in >= rt) begin
                result <= rv;
                sub    <= 2'd3;
              end else begin
                sub <= 2'd1;
              end
            end
            2'd1: begin
              prod <= NB'(dt) * NB'(mag);
              sub  <= 2'd2;
            end
            2'd2: begin
              sub <= 2'd3;
              first <= 1'b0;
            end
            default: begin
              if (!first && !div_busy) begin
                result <= neg ? vl - VB'(quot) : vl + VB'(quot);
                first  <= 1'b1;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      out_word.status      <= status;
      out_word.value_out   <= result;
      out_word.point_count <= count;
      out_word.min_value   <= vmin;
      out_word.max_value   <= vmax;
    end
  end

  a_cnt : assert property (@(posedge clk) disable iff (rst)
    count <= CountBits'(TABLE_DEPTH))
    else $error("point count above depth");
  a_busy : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_word))
    else $error("result changed under stall");
  a_minmax : assert property (@(posedge clk) disable iff (rst)
    count != '0 |-> vmin <= vmax)
    else $error("minimum above maximum");

endmodule

### verif/tb_breakpoint_table_interpolator.sv
`timescale 1ns / 100ps
// self-checking bench for the breakpoint table interpolator
// depends on bti_pkg and breakpoint_table_interpolator; holds its own table predictor
module tb_breakpoint_table_interpolator;
  import bti_pkg::*;

  localparam int CycleLimit = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  // predictor copy of the table
  logic [31:0] tbl_time [TableDepth];
  logic signed [31:0] tbl_val [TableDepth];
  int unsigned tbl_count = 0;
  logic signed [31:0] tbl_min = '0;
  logic signed [31:0] tbl_max = '0;

  out_word_t pending_words[$];
  int fail_count = 0;
  int word_count = 0;
  int query_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  longint cycle_count = 0;

  breakpoint_table_interpolator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #1 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stalling, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // truncated interpolation between two points, exact over 64 bits
  function automatic logic signed [31:0] lerp_value(logic [31:0] t, int unsigned il);
    logic [63:0] dt, span, mag, q;
    logic signed [63:0] fl, fr;
    logic [127:0] prod;
    fl = tbl_val[il];
    fr = tbl_val[il+1];
    dt = t - tbl_time[il];
    span = tbl_time[il+1] - tbl_time[il];
    mag = (fr < fl) ? fl - fr : fr - fl;
    prod = dt * mag;
    q = prod / span;
    return (fr < fl) ? 32'(fl - $signed(q)) : 32'(fl + $signed(q));
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    int unsigned pos, lo, hi, m;
    r = '0;
    case (cmd_t'(w.cmd))
      CMD_CLEAR: begin
        tbl_count = 0; tbl_min = '0; tbl_max = '0;
      end
      CMD_INSERT: begin
        pos = 0;
        while (pos < tbl_count && tbl_time[pos] < w.time_in) pos++;
        if (pos < tbl_count && tbl_time[pos] == w.time_in) r.status = ST_DUP;
        else if (tbl_count >= TableDepth) r.status = ST_FULL;
        else begin
          for (int i = tbl_count; i > pos; i--) begin
            tbl_time[i] = tbl_time[i-1];
            tbl_val[i] = tbl_val[i-1];
          end
          tbl_time[pos] = w.time_in;
          tbl_val[pos] = w.value_in;
          if (tbl_count == 0) begin
            tbl_min = w.value_in; tbl_max = w.value_in;
          end else begin
            if (w.value_in < tbl_min) tbl_min = w.value_in;
            if (w.value_in > tbl_max) tbl_max = w.value_in;
          end
          tbl_count++;
        end
      end
      CMD_QUERY: begin
        if (tbl_count == 0) r.status = ST_EMPTY;
        else if (w.time_in <= tbl_time[0]) r.value_out = tbl_val[0];
        else if (w.time_in >= tbl_time[tbl_count-1]) r.value_out = tbl_val[tbl_count-1];
        else begin
          lo = 0; hi = tbl_count - 1;
          while (hi - lo > 1) begin
            m = lo + (hi - lo) / 2;
            if (tbl_time[m] <= w.time_in) lo = m; else hi = m;
          end
          if (w.time_in == tbl_time[lo+1]) r.value_out = tbl_val[lo+1];
          else r.value_out = lerp_value(w.time_in, lo);
        end
      end
      default: ;
    endcase
    r.point_count = tbl_count[8:0];
    r.min_value = tbl_min;
    r.max_value = tbl_max;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      word_count++;
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        e = pending_words.pop_front();
        if (out_word.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_word.status); fail_count++;
        end
        if (out_word.value_out !== e.value_out) begin
          $error("value_out exp %0d got %0d", e.value_out, out_word.value_out); fail_count++;
        end
        if (out_word.point_count !== e.point_count) begin
          $error("point_count exp %0d got %0d", e.point_count, out_word.point_count);
          fail_count++;
        end
        if (out_word.min_value !== e.min_value) begin
          $error("min_value exp %0d got %0d", e.min_value, out_word.min_value); fail_count++;
        end
        if (out_word.max_value !== e.max_value) begin
          $error("max_value exp %0d got %0d", e.max_value, out_word.max_value); fail_count++;
        end
      end
    end
  end

  // send one word; expectation is queued at acceptance, valid drops only when idling
  task automatic send_word(cmd_t c, logic [31:0] t, logic signed [31:0] v);
    in_word_t w;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    w.cmd = c; w.time_in = t; w.value_in = v;
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_words.push_back(predict_word(w));
    if (c == CMD_QUERY) query_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(4))
      0: return $urandom_range(300);
      1: return 32'hffffffff - $urandom_range(300);
      default: return $urandom;
    endcase
  endfunction

  // extremes, every command and the named corner cases
  task automatic test_directed();
    send_word(CMD_QUERY, 32'd5, 32'sd0);
    send_word(CMD_NOP, 32'hffffffff, 32'h7fffffff);
    send_word(CMD_INSERT, 32'd100, 32'sd1000);
    send_word(CMD_INSERT, 32'd100, 32'sd5);
    send_word(CMD_QUERY, 32'd0, 32'sd0);
    send_word(CMD_QUERY, 32'hffffffff, 32'sd0);
    send_word(CMD_INSERT, 32'd0, 32'h80000000);
    send_word(CMD_INSERT, 32'hffffffff, 32'h7fffffff);
    send_word(CMD_INSERT, 32'd200, -32'sd7);
    send_word(CMD_QUERY, 32'd100, 32'sd0);
    send_word(CMD_QUERY, 32'd200, 32'sd0);
    send_word(CMD_QUERY, 32'd150, 32'sd0);
    send_word(CMD_QUERY, 32'd1, 32'sd0);
    send_word(CMD_QUERY, 32'hfffffffe, 32'sd0);
    send_word(CMD_QUERY, 32'h80000000, 32'hffffffff);
    send_word(CMD_CLEAR, 32'hffffffff, 32'hffffffff);
    send_word(CMD_QUERY, 32'd100, 32'sd0);
    // fill to capacity then probe full and duplicate ordering
    for (int i = 0; i < TableDepth; i++) send_word(CMD_INSERT, 32'(i * 3 + 1), rand_value());
    send_word(CMD_INSERT, 32'd4, 32'sd9);
    send_word(CMD_INSERT, 32'd5, 32'sd9);
    send_word(CMD_QUERY, 32'd6, 32'sd0);
    send_word(CMD_CLEAR, 32'd0, 32'sd0);
  endtask

  // random sequences: build a table, query it, occasionally clear
  task automatic test_random(int n_items);
    for (int k = 0; k < n_items; k++) begin
      int r;
      r = $urandom_range(99);
      if (r < 2) send_word(CMD_CLEAR, $urandom, $urandom);
      else if (r < 4) send_word(CMD_NOP, $urandom, $urandom);
      else if (r < 40 && tbl_count < 40)
        send_word(CMD_INSERT, rand_time(), rand_value());
      else if (r < 45 && tbl_count > 0)
        send_word(CMD_INSERT, tbl_time[$urandom_range(tbl_count-1)], rand_value());
      else if (r < 55 && tbl_count > 0)
        send_word(CMD_QUERY, tbl_time[$urandom_range(tbl_count-1)], $urandom);
      else send_word(CMD_QUERY, rand_time(), $urandom);
    end
  endtask

  // receiver holds off while sender keeps offering, then sender waits out the drain
  task automatic test_backpressure();
    hold_cycles = 3000;
    test_random(20);
    wait_drained();
    test_random(10);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    send_idle_pct = 0; stall_pct = 0;
    test_random(300);
    send_idle_pct = 81; stall_pct = 0;
    test_random(300);
    send_idle_pct = 0; stall_pct = 81;
    test_random(300);
    send_idle_pct = 9; stall_pct = 9;
    test_random(300);
    send_idle_pct = 0; stall_pct = 0;
    test_backpressure();
    wait_drained();
    repeat (1200) @(negedge clk);
    $display("run covered %0d result words, %0d of them queries, over idle and stall phases",
             word_count, query_count);
    if (fail_count == 0 && pending_words.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
